FILE: src/uqsd_pkg.sv
// Shared types and constants for the URL query string decoder.
`default_nettype none
package uqsd_pkg;

  // Result kinds on the output channel
  localparam logic [1:0] KIND_KEY       = 2'd0;
  localparam logic [1:0] KIND_VALUE     = 2'd1;
  localparam logic [1:0] KIND_PAIR_END  = 2'd2;
  localparam logic [1:0] KIND_QUERY_END = 2'd3;

  // Special characters
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_AMP     = 8'h26;
  localparam logic [7:0] CH_EQUAL   = 8'h3D;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  // Default depth of the queue between front and back
  localparam int QUEUE_DEPTH_DEF = 4;

  // Everything one input word produces, in output order: data, pair end, query end
  typedef struct packed {
    logic       has_data;
    logic       is_value;
    logic [7:0] data;
    logic       has_pair_end;
    logic       has_query_end;
    logic       ok;
  } uqsd_bundle_t;

endpackage
`default_nettype wire

FILE: src/uqsd_front.sv
// Front end: accepts raw bytes, tracks parse state, builds one result bundle per byte.
`default_nettype none
module uqsd_front (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  accept,
  input  wire logic [7:0]            in_byte,
  input  wire logic                  in_last,
  output logic                       bundle_push,
  output uqsd_pkg::uqsd_bundle_t     bundle
);
  import uqsd_pkg::*;

  localparam logic [1:0] ESC_NONE = 2'd0;
  localparam logic [1:0] ESC_HI   = 2'd1;
  localparam logic [1:0] ESC_LO   = 2'd2;

  logic       value_part_r, value_part_nxt;
  logic [1:0] esc_r, esc_nxt;
  logic [3:0] hi_nib_r, hi_nib_nxt;
  logic       err_r, err_nxt;
  logic       pair_open_r, pair_open_nxt;

  logic       is_hex;
  logic [3:0] hex_val;
  logic       err_fin;

  // Hex digit decode, either case
  always_comb begin
    is_hex  = 1'b0;
    hex_val = 4'd0;
    if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
      is_hex  = 1'b1;
      hex_val = 4'(in_byte - 8'h30);
    end else if (in_byte >= 8'h61 && in_byte <= 8'h66) begin
      is_hex  = 1'b1;
      hex_val = 4'(in_byte - 8'h57);
    end else if (in_byte >= 8'h41 && in_byte <= 8'h46) begin
      is_hex  = 1'b1;
      hex_val = 4'(in_byte - 8'h37);
    end
  end

  // Next state and result bundle for the current byte
  always_comb begin
    value_part_nxt = value_part_r;
    esc_nxt        = esc_r;
    hi_nib_nxt     = hi_nib_r;
    err_nxt        = err_r;
    pair_open_nxt  = pair_open_r;
    bundle         = '0;
    bundle.is_value = value_part_r;
    err_fin        = 1'b0;

    if (!err_r) begin
      if (esc_r != ESC_NONE) begin
        if (!is_hex) begin
          err_nxt = 1'b1;
          esc_nxt = ESC_NONE;
        end else if (esc_r == ESC_HI) begin
          hi_nib_nxt = hex_val;
          esc_nxt    = ESC_LO;
        end else begin
          bundle.has_data = 1'b1;
          bundle.data     = {hi_nib_r, hex_val};
          esc_nxt         = ESC_NONE;
        end
      end else if (in_byte == CH_AMP) begin
        bundle.has_pair_end = pair_open_r;
        pair_open_nxt       = 1'b0;
        value_part_nxt      = 1'b0;
      end else if (in_byte == CH_PERCENT) begin
        pair_open_nxt = 1'b1;
        esc_nxt       = ESC_HI;
      end else if (in_byte == CH_EQUAL && !value_part_r) begin
        pair_open_nxt  = 1'b1;
        value_part_nxt = 1'b1;
      end else begin
        pair_open_nxt   = 1'b1;
        bundle.has_data = 1'b1;
        bundle.data     = (in_byte == CH_PLUS) ? CH_SPACE : in_byte;
      end
    end

    // Final byte closes an open pair (unless in error) and the query, then state clears
    if (in_last) begin
      err_fin = err_nxt | (esc_nxt != ESC_NONE);
      if (!err_fin && pair_open_nxt) begin
        bundle.has_pair_end = 1'b1;
      end
      bundle.has_query_end = 1'b1;
      bundle.ok            = ~err_fin;
      value_part_nxt       = 1'b0;
      esc_nxt              = ESC_NONE;
      hi_nib_nxt           = 4'd0;
      err_nxt              = 1'b0;
      pair_open_nxt        = 1'b0;
    end
  end

  assign bundle_push = accept &
                       (bundle.has_data | bundle.has_pair_end | bundle.has_query_end);

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      value_part_r <= 1'b0;
      esc_r        <= ESC_NONE;
      hi_nib_r     <= 4'd0;
      err_r        <= 1'b0;
      pair_open_r  <= 1'b0;
    end else if (accept) begin
      value_part_r <= value_part_nxt;
      esc_r        <= esc_nxt;
      hi_nib_r     <= hi_nib_nxt;
      err_r        <= err_nxt;
      pair_open_r  <= pair_open_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: src/uqsd_queue.sv
// Small register queue of result bundles between front and back.
`default_nettype none
module uqsd_queue #(
  parameter int DEPTH = uqsd_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  input  wire uqsd_pkg::uqsd_bundle_t push_data,
  output logic                       full,
  input  wire logic                  pop,
  output logic                       head_valid,
  output uqsd_pkg::uqsd_bundle_t     head
);
  import uqsd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  uqsd_bundle_t     mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];
  assign do_push    = push & ~full;
  assign do_pop     = pop & head_valid;

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

FILE: src/uqsd_back.sv
// Back end: walks the head bundle and presents its results one word at a time.
`default_nettype none
module uqsd_back (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   head_valid,
  input  wire uqsd_pkg::uqsd_bundle_t head,
  output logic                        head_pop,
  output logic                        empty,
  input  wire logic                   pop,
  output logic [1:0]                  out_result_kind,
  output logic [7:0]                  out_decoded_byte,
  output logic                        out_query_ok,
  output logic                        out_last
);
  import uqsd_pkg::*;

  // bit 0 data, bit 1 pair end, bit 2 query end
  logic [2:0] done_r, done_nxt;
  logic [2:0] present, left, cur;
  logic       take;

  assign present = {head.has_query_end, head.has_pair_end, head.has_data};
  assign left    = present & ~done_r;
  assign cur     = left & (~left + 3'd1);
  assign empty   = ~head_valid;
  assign take    = pop & head_valid;
  assign out_last = ((left & ~cur) == 3'b000);
  assign head_pop = take & out_last;

  // Result fields of the selected entry
  always_comb begin
    out_result_kind  = KIND_QUERY_END;
    out_decoded_byte = 8'd0;
    out_query_ok     = 1'b0;
    if (cur[0]) begin
      out_result_kind  = head.is_value ? KIND_VALUE : KIND_KEY;
      out_decoded_byte = head.data;
    end else if (cur[1]) begin
      out_result_kind = KIND_PAIR_END;
    end else begin
      out_query_ok = head.ok;
    end
  end

  always_comb begin
    done_nxt = done_r;
    if (take) begin
      done_nxt = out_last ? 3'b000 : (done_r | cur);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 3'b000;
    end else begin
      done_r <= done_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: src/url_query_string_decoder.sv
// Top level of the URL query string decoder.
// Decodes an application/x-www-form-urlencoded query string, one byte per word
// on the input queue (in_last on the final byte). Each byte is taken by the
// front parser and turned into up to three results (key/value byte, pair end,
// query end), which go through a small bundle queue to the back end; the back
// end presents one result word per cycle while pop is high. Input runs at one
// byte per cycle as long as results are popped as fast as they are made; a byte
// with several results stays at the queue head until all are popped, and full
// rises once QUEUE_DEPTH bundles are waiting. A malformed or truncated escape
// mutes further output until the query end, which then carries out_query_ok = 0.
`default_nettype none
module url_query_string_decoder #(
  parameter int QUEUE_DEPTH = uqsd_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  output logic            empty,
  input  wire logic       pop,
  output logic [1:0]      out_result_kind,
  output logic [7:0]      out_decoded_byte,
  output logic            out_query_ok,
  output logic            out_last
);
  import uqsd_pkg::*;

  logic         accept;
  logic         bundle_push;
  uqsd_bundle_t bundle;
  logic         head_valid;
  uqsd_bundle_t head;
  logic         head_pop;

  assign accept = push & ~full;

  uqsd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .in_byte     (in_byte),
    .in_last     (in_last),
    .bundle_push (bundle_push),
    .bundle      (bundle)
  );

  uqsd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (bundle_push),
    .push_data  (bundle),
    .full       (full),
    .pop        (head_pop),
    .head_valid (head_valid),
    .head       (head)
  );

  uqsd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head_valid       (head_valid),
    .head             (head),
    .head_pop         (head_pop),
    .empty            (empty),
    .pop              (pop),
    .out_result_kind  (out_result_kind),
    .out_decoded_byte (out_decoded_byte),
    .out_query_ok     (out_query_ok),
    .out_last         (out_last)
  );

endmodule
`default_nettype wire

FILE: tb/sv/url_query_string_decoder_tb.sv
// Self-checking testbench for the URL query string decoder: directed and random queries.
module url_query_string_decoder_tb;
  import uqsd_pkg::*;

  typedef enum logic [1:0] {ESC_NONE, ESC_HIGH, ESC_LOW} esc_phase_t;

  typedef struct {
    logic [7:0] b;
    logic       last;
  } query_byte_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       ok;
    logic       last;
  } result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] in_byte = 8'h00;
  logic       in_last = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic [1:0] out_result_kind;
  logic [7:0] out_decoded_byte;
  logic       out_query_ok;
  logic       out_last;

  query_byte_t query_stream[$];
  logic [7:0]  query_chars[$];
  result_t     expected_results[$];
  int          mismatches = 0;

  // Decoder state as seen by the predictor
  logic       dec_value_part = 1'b0;
  esc_phase_t dec_esc = ESC_NONE;
  logic [3:0] dec_high = 4'h0;
  logic       dec_err = 1'b0;
  logic       dec_pair_open = 1'b0;

  // Sender burst / gap counters
  int burst_left = 8;
  int gap_left = 0;
  // Receiver stall pattern
  int rx_cycle = 0;
  int rx_mode = 0;

  url_query_string_decoder DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_byte          (in_byte),
    .in_last          (in_last),
    .empty            (empty),
    .pop              (pop),
    .out_result_kind  (out_result_kind),
    .out_decoded_byte (out_decoded_byte),
    .out_query_ok     (out_query_ok),
    .out_last         (out_last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // {valid, nibble} for a hex digit in either case
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c >= "0" && c <= "9") begin
      d = c - "0";
      return {1'b1, d[3:0]};
    end
    if (c >= "a" && c <= "f") begin
      d = c - "a" + 8'd10;
      return {1'b1, d[3:0]};
    end
    if (c >= "A" && c <= "F") begin
      d = c - "A" + 8'd10;
      return {1'b1, d[3:0]};
    end
    return 5'h00;
  endfunction

  function automatic result_t make_result(input logic [1:0] kind, input logic [7:0] data,
                                          input logic ok);
    result_t r;
    r.kind = kind;
    r.data = data;
    r.ok = ok;
    r.last = 1'b0;
    return r;
  endfunction

  // Append one character to the query under construction
  task automatic add_char(input logic [7:0] c);
    query_chars.insert(query_chars.size(), c);
  endtask

  // Advance the decoder state by one query byte and queue the words it yields
  task automatic decode_step(input logic [7:0] c, input logic fin);
    result_t    res[3];
    int         n;
    logic [4:0] hv;
    logic [1:0] data_kind;
    n = 0;
    hv = hex_value(c);
    data_kind = dec_value_part ? KIND_VALUE : KIND_KEY;
    if (!dec_err) begin
      if (dec_esc != ESC_NONE) begin
        if (!hv[4]) begin
          dec_err = 1'b1;
          dec_esc = ESC_NONE;
        end else if (dec_esc == ESC_HIGH) begin
          dec_high = hv[3:0];
          dec_esc = ESC_LOW;
        end else begin
          res[n] = make_result(data_kind, {dec_high, hv[3:0]}, 1'b0);
          n++;
          dec_esc = ESC_NONE;
        end
      end else if (c == CH_AMP) begin
        if (dec_pair_open) begin
          res[n] = make_result(KIND_PAIR_END, 8'h00, 1'b0);
          n++;
        end
        dec_pair_open = 1'b0;
        dec_value_part = 1'b0;
      end else if (c == CH_PERCENT) begin
        dec_pair_open = 1'b1;
        dec_esc = ESC_HIGH;
      end else if (c == CH_EQUAL && !dec_value_part) begin
        dec_pair_open = 1'b1;
        dec_value_part = 1'b1;
      end else begin
        dec_pair_open = 1'b1;
        res[n] = make_result(data_kind, (c == CH_PLUS) ? CH_SPACE : c, 1'b0);
        n++;
      end
    end
    // query end closes an open pair unless in error, and clears everything
    if (fin) begin
      if (dec_esc != ESC_NONE) dec_err = 1'b1;
      if (!dec_err && dec_pair_open) begin
        res[n] = make_result(KIND_PAIR_END, 8'h00, 1'b0);
        n++;
      end
      res[n] = make_result(KIND_QUERY_END, 8'h00, !dec_err);
      n++;
      dec_value_part = 1'b0;
      dec_esc = ESC_NONE;
      dec_high = 4'h0;
      dec_err = 1'b0;
      dec_pair_open = 1'b0;
    end
    if (n > 0) res[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) expected_results.insert(expected_results.size(), res[i]);
  endtask

  // Query assembly: collect characters, then flag the final one
  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_char(s[i]);
  endtask

  task automatic end_query();
    query_byte_t w;
    if (query_chars.size() == 0) add_char(CH_AMP);
    foreach (query_chars[i]) begin
      w.b = query_chars[i];
      w.last = (i == query_chars.size() - 1);
      query_stream.insert(query_stream.size(), w);
    end
    query_chars.delete();
  endtask

  function automatic logic [7:0] rand_hex_char();
    int v;
    v = $urandom_range(0, 15);
    if (v < 10) return 8'(v) + "0";
    return 8'(v - 10) + (($urandom_range(0, 1) == 1) ? "a" : "A");
  endfunction

  function automatic logic [7:0] rand_non_hex();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while (hex_value(c) != 5'h00) c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  task automatic add_random_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      add_char(8'($urandom_range(8'h30, 8'h7a)));
    end else if (r < 60) begin
      add_char(CH_PLUS);
    end else if (r < 85) begin
      add_char(CH_PERCENT);
      add_char(rand_hex_char());
      add_char(rand_hex_char());
    end else if (r < 95) begin
      add_char(CH_EQUAL);
    end else begin
      add_char(8'($urandom_range(0, 255)));
    end
  endtask

  // Mostly well-formed pairs; some queries carry a bad or cut-off escape
  task automatic add_random_query();
    int npairs;
    int klen;
    int vlen;
    npairs = $urandom_range(0, 4);
    for (int p = 0; p < npairs; p++) begin
      if (p > 0 || $urandom_range(0, 7) == 0) add_char(CH_AMP);
      if ($urandom_range(0, 7) == 0) add_char(CH_AMP);
      klen = $urandom_range(0, 3);
      for (int i = 0; i < klen; i++) add_random_char();
      if ($urandom_range(0, 3) != 0) add_char(CH_EQUAL);
      vlen = $urandom_range(0, 4);
      for (int i = 0; i < vlen; i++) add_random_char();
    end
    if ($urandom_range(0, 6) == 0) begin
      add_char(CH_PERCENT);
      case ($urandom_range(0, 2))
        0: begin
          add_char(rand_non_hex());
          add_random_char();
          add_char(CH_AMP);
          add_random_char();
        end
        1: ;
        default: add_char(rand_hex_char());
      endcase
    end else if ($urandom_range(0, 5) == 0) begin
      add_char(CH_AMP);
    end
    end_query();
  endtask

  // Driver: bursts of words with random gaps; a word is held until taken
  always @(posedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        decode_step(in_byte, in_last);
        void'(query_stream.pop_front());
      end
      if (push && full) begin
        // hold the current word
      end else if (gap_left != 0) begin
        gap_left = gap_left - 1;
        push <= 1'b0;
      end else if (query_stream.size() != 0) begin
        push <= 1'b1;
        in_byte <= query_stream[0].b;
        in_last <= query_stream[0].last;
        burst_left = burst_left - 1;
        if (burst_left <= 0) begin
          burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                    : $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 7);
        end
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Monitor: check each popped word, then pick the next pop from the stall pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          $error("result word with nothing expected: kind %0d byte %0h",
                 out_result_kind, out_decoded_byte);
          mismatches++;
        end else begin
          result_t exp_r;
          exp_r = expected_results.pop_front();
          if (out_result_kind !== exp_r.kind) begin
            $error("out_result_kind: expected %0d, got %0d", exp_r.kind, out_result_kind);
            mismatches++;
          end
          if (out_decoded_byte !== exp_r.data) begin
            $error("out_decoded_byte: expected %0h, got %0h", exp_r.data, out_decoded_byte);
            mismatches++;
          end
          if (out_query_ok !== exp_r.ok) begin
            $error("out_query_ok: expected %0d, got %0d", exp_r.ok, out_query_ok);
            mismatches++;
          end
          if (out_last !== exp_r.last) begin
            $error("out_last: expected %0d, got %0d", exp_r.last, out_last);
            mismatches++;
          end
        end
      end
      rx_cycle++;
      if (rx_cycle % 64 == 0) rx_mode = $urandom_range(0, 3);
      case (rx_mode)
        0: pop <= 1'b1;
        1: pop <= ($urandom_range(0, 1) == 1);
        2: pop <= (rx_cycle % 4 == 0);
        default: pop <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Stimulus and end of run
  initial begin
    // empty pair, '=' into value, upper-case escape, pair end on '&'
    add_text("&=x%4A&");
    end_query();
    // second '=' is literal, mixed-case escape, '+' as space, three words on last byte
    add_text("k==%fF+");
    end_query();
    // non-hex digit inside an escape
    add_text("%0g");
    end_query();
    // escape cut off by the final byte
    add_text("%");
    end_query();
    // pair holding only '='
    add_text("=");
    end_query();
    // raw byte extremes
    add_char(8'h00);
    add_char(8'hFF);
    end_query();
    // '&' inside an escape, output muted afterwards
    add_text("%&b");
    end_query();

    while (query_stream.size() < 200) add_random_query();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (query_stream.size() != 0 || push) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("url_query_string_decoder: match");
    end else begin
      $display("url_query_string_decoder: mismatch");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #3000000;
    $display("url_query_string_decoder: mismatch");
    $finish;
  end

endmodule
